// ===== sv/pfa_pkg.sv =====
// shared constants, codes and controller/datapath interface types of the frame allocator
package pfa_pkg;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int SIZE_W     = 16;
   localparam int PID_W      = 16;
   localparam int STAT_W     = 2;
   localparam int OUT_ID_W   = 16;
   localparam int OUT_IDX_W  = 6;
   localparam int OUT_CNT_W  = 7;
   localparam int PSIZE_W    = 11;
   localparam int FRAMES_W   = 7;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_FRAMES = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PAGE_SIZE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAMES    = 1'b1;

   // reset values of the registers
   localparam logic [PSIZE_W-1:0]  PAGE_SIZE_RST = 11'd4;
   localparam logic [FRAMES_W-1:0] FRAMES_RST    = 7'd64;

   typedef struct packed {
      logic              load_req;
      logic              div_step;
      logic              start_alloc;
      logic              take_frame;
      logic              dec_left;
      logic              restart_scan;
      logic              clear_owner;
      logic              finish_remove;
      logic              do_clear;
      logic              emit_map;
      logic              emit_single;
      logic [STAT_W-1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] req_op;
      logic            req_size_zero;
      logic            active_zero;
      logic            rem_zero;
      logic            pages_eq_free;
      logic            left_one;
      logic            pg_last;
      logic            slot_free;
      logic            frame_free;
      logic            frame_emit;
      logic            frame_owned;
      logic            freed_zero;
   } stat_type;

endpackage

// ===== sv/paged_frame_allocator.sv =====
// Paged frame allocator: keeps owner and logical page for each of NUM_FRAMES physical frames
// and serves allocate, remove and clear items one at a time. An allocate first counts pages
// by repeated subtraction of the page size, one page per step, and stops when the size is zero
// or pages equal free frames. It then walks the active frames from the highest down twice,
// with a read state and a check state per frame because of the registered table read: once to
// claim free frames and once to emit the mappings in page order. Either walk stops once the
// last page is reached, and the emit walk holds while the output register cannot take a result.
// A remove walks all active frames once; a clear goes straight to its result. One result item
// waits in the output register while the next input item is accepted. Writing the frame count
// register clears the table just like a clear item; page size is read while an allocate counts.
module paged_frame_allocator #(
   parameter int NUM_FRAMES = 64,
   parameter int ID_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pfa_pkg::REQ_DATA_W-1:0] req_tdata,   // process_size_kb, process_number
   input  logic [pfa_pkg::OP_W-1:0]       req_tuser,   // op
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // assigned_id, page_number, frame_number, free_count, zero pad
   output logic [pfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [pfa_pkg::STAT_W-1:0]     rsp_tuser,   // status
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [pfa_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pfa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pfa_pkg::cmd_type  cmd;
   pfa_pkg::stat_type stat;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfa_dp #(
      .NUM_FRAMES(NUM_FRAMES),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // failures never come as part of a mapping run
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != pfa_pkg::ST_OK)) |-> rsp_tlast)
      else $error("failure result without last");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:28] <= pfa_pkg::OUT_CNT_W'(NUM_FRAMES)))
      else $error("free count above frame count");

   a_bad_size_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == pfa_pkg::ST_BAD_SIZE)) |-> (rsp_tdata[15:0] == '0))
      else $error("rejected allocate carries an id");

   // frame claims, mapping emits and owner clears only while an item is in work
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(cmd.take_frame || cmd.emit_map || cmd.clear_owner))
      else $error("table activity while idle");

endmodule

// ===== sv/pfa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/pfa_dp.sv =====
// frame allocator datapath: registers, frame table, page count unit and result register
module pfa_dp #(
   parameter int NUM_FRAMES = 64,
   parameter int ID_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [pfa_pkg::OP_W-1:0]           req_tuser,
   input  logic                               csr_we,
   input  logic [pfa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  pfa_pkg::cmd_type                   cmd,
   output pfa_pkg::stat_type                  stat,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [pfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [pfa_pkg::STAT_W-1:0]         rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
   localparam int ENTRY_W    = ID_BITS + FRAME_BITS;
   localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

   function automatic logic [CNT_BITS-1:0] active_count(input logic [pfa_pkg::FRAMES_W-1:0] f);
      logic [CNT_BITS-1:0] r;
      if (f > pfa_pkg::FRAMES_W'(NUM_FRAMES)) begin
         r = CNT_BITS'(NUM_FRAMES);
      end else begin
         r = CNT_BITS'(f);
      end
      return r;
   endfunction

   // configuration
   logic [pfa_pkg::PSIZE_W-1:0]  page_size_ff, page_size_in;
   logic [pfa_pkg::FRAMES_W-1:0] frames_ff, frames_in;
   // frame table state
   logic [NUM_FRAMES-1:0]        valid_ff, valid_in;
   logic [CNT_BITS-1:0]          free_ff, free_in;
   logic [ID_BITS-1:0]           next_id_ff, next_id_in;
   // per-item working registers
   logic [ID_BITS-1:0]           cur_id_ff, cur_id_in;
   logic [pfa_pkg::OP_W-1:0]     op_ff, op_in;
   logic [pfa_pkg::SIZE_W-1:0]   rem_ff, rem_in;
   logic [pfa_pkg::PID_W-1:0]    pid_ff, pid_in;
   logic [CNT_BITS-1:0]          pages_ff, pages_in;
   logic [CNT_BITS-1:0]          pg_ff, pg_in;
   logic [CNT_BITS-1:0]          left_ff, left_in;
   logic [CNT_BITS-1:0]          freed_ff, freed_in;
   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [pfa_pkg::OUT_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [pfa_pkg::OUT_IDX_W-1:0] rsp_page_ff, rsp_page_in;
   logic [pfa_pkg::OUT_IDX_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic [pfa_pkg::OUT_CNT_W-1:0] rsp_free_ff, rsp_free_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [CNT_BITS-1:0]          active_n;
   logic [CNT_BITS-1:0]          clear_n;
   logic                         frames_write;
   logic [pfa_pkg::PSIZE_W-1:0]  eff_ps;
   logic [pfa_pkg::SIZE_W-1:0]   ps_ext;
   logic [FRAME_BITS-1:0]        idx;
   logic [CNT_BITS-1:0]          pg_next;
   logic [ID_BITS-1:0]           want_id;
   logic [ENTRY_W-1:0]           rd_entry;
   logic [ID_BITS-1:0]           rd_owner;
   logic [FRAME_BITS-1:0]        rd_page;
   logic                         slot_free;

   assign active_n     = active_count(frames_ff);
   assign frames_write = csr_we && (csr_addr == pfa_pkg::CSR_FRAMES);
   assign clear_n      = frames_write ? active_count(csr_wdata[pfa_pkg::FRAMES_W-1:0]) : active_n;
   assign eff_ps       = (page_size_ff == '0) ? pfa_pkg::PSIZE_W'(1) : page_size_ff;
   assign ps_ext       = pfa_pkg::SIZE_W'(eff_ps);
   // scan runs downward: frame index is the remaining count minus one
   assign idx          = FRAME_BITS'(left_ff - CNT_BITS'(1));
   assign pg_next      = pg_ff + CNT_BITS'(1);
   assign want_id      = ID_BITS'(pid_ff);
   assign slot_free    = !rsp_valid_ff || rsp_tready;

   pfa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_FRAMES)
   ) u_table (
      .clock(clock),
      .we   (cmd.take_frame),
      .waddr(idx),
      .wdata({cur_id_ff, FRAME_BITS'(pg_ff)}),
      .raddr(idx),
      .rdata(rd_entry)
   );

   assign rd_owner = rd_entry[ENTRY_W-1:FRAME_BITS];
   assign rd_page  = rd_entry[FRAME_BITS-1:0];

   always_comb begin
      stat.req_op        = req_tuser;
      stat.req_size_zero = (req_tdata[pfa_pkg::SIZE_W-1:0] == '0);
      stat.active_zero   = (active_n == '0);
      stat.rem_zero      = (rem_ff == '0);
      stat.pages_eq_free = (pages_ff == free_ff);
      stat.left_one      = (left_ff == CNT_BITS'(1));
      stat.pg_last       = (pg_next == pages_ff);
      stat.slot_free     = slot_free;
      stat.frame_free    = !valid_ff[idx];
      stat.frame_emit    = valid_ff[idx] && (rd_owner == cur_id_ff) &&
                           (rd_page == FRAME_BITS'(pg_ff));
      stat.frame_owned   = valid_ff[idx] && (rd_owner == want_id);
      stat.freed_zero    = (freed_ff == '0);
   end

   always_comb begin
      page_size_in  = page_size_ff;
      frames_in     = frames_ff;
      valid_in      = valid_ff;
      free_in       = free_ff;
      next_id_in    = next_id_ff;
      cur_id_in     = cur_id_ff;
      op_in         = op_ff;
      rem_in        = rem_ff;
      pid_in        = pid_ff;
      pages_in      = pages_ff;
      pg_in         = pg_ff;
      left_in       = left_ff;
      freed_in      = freed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load_req) begin
         op_in    = req_tuser;
         rem_in   = req_tdata[pfa_pkg::SIZE_W-1:0];
         pid_in   = req_tdata[pfa_pkg::SIZE_W +: pfa_pkg::PID_W];
         pages_in = '0;
         pg_in    = '0;
         left_in  = active_n;
         freed_in = '0;
      end
      // one page per step, saturating at zero for the rounded-up last page
      if (cmd.div_step) begin
         rem_in   = (rem_ff > ps_ext) ? (rem_ff - ps_ext) : '0;
         pages_in = pages_ff + CNT_BITS'(1);
      end
      if (cmd.start_alloc) begin
         free_in    = free_ff - pages_ff;
         cur_id_in  = next_id_ff;
         next_id_in = (next_id_ff == ID_MAX) ? ID_BITS'(1) : next_id_ff + ID_BITS'(1);
      end
      if (cmd.take_frame) begin
         valid_in[idx] = 1'b1;
         pg_in         = pg_next;
      end
      if (cmd.emit_map) begin
         pg_in = pg_next;
      end
      if (cmd.dec_left) begin
         left_in = left_ff - CNT_BITS'(1);
      end
      if (cmd.restart_scan) begin
         left_in = active_n;
         pg_in   = '0;
      end
      if (cmd.clear_owner) begin
         valid_in[idx] = 1'b0;
         freed_in      = freed_ff + CNT_BITS'(1);
      end
      if (cmd.finish_remove) begin
         free_in = free_ff + freed_ff;
      end
      if (cmd.do_clear || frames_write) begin
         valid_in   = '0;
         free_in    = clear_n;
         next_id_in = ID_BITS'(1);
      end

      if (csr_we) begin
         case (csr_addr)
            pfa_pkg::CSR_PAGE_SIZE: begin
               page_size_in = csr_wdata[pfa_pkg::PSIZE_W-1:0];
            end
            pfa_pkg::CSR_FRAMES: begin
               frames_in = csr_wdata[pfa_pkg::FRAMES_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.emit_map) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pfa_pkg::ST_OK;
         rsp_id_in     = pfa_pkg::OUT_ID_W'(cur_id_ff);
         rsp_page_in   = pfa_pkg::OUT_IDX_W'(pg_ff);
         rsp_frame_in  = pfa_pkg::OUT_IDX_W'(idx);
         rsp_free_in   = pfa_pkg::OUT_CNT_W'(free_ff);
         rsp_last_in   = (pg_next == pages_ff);
      end else if (cmd.emit_single) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_id_in     = (op_ff == pfa_pkg::OP_REMOVE) ? pid_ff : '0;
         rsp_page_in   = '0;
         rsp_frame_in  = '0;
         rsp_free_in   = pfa_pkg::OUT_CNT_W'(free_ff);
         rsp_last_in   = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= pfa_pkg::PAGE_SIZE_RST;
         frames_ff    <= pfa_pkg::FRAMES_RST;
         valid_ff     <= '0;
         free_ff      <= active_count(pfa_pkg::FRAMES_RST);
         next_id_ff   <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         page_size_ff <= page_size_in;
         frames_ff    <= frames_in;
         valid_ff     <= valid_in;
         free_ff      <= free_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_id_ff     <= cur_id_in;
      op_ff         <= op_in;
      rem_ff        <= rem_in;
      pid_ff        <= pid_in;
      pages_ff      <= pages_in;
      pg_ff         <= pg_in;
      left_ff       <= left_in;
      freed_ff      <= freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b00000, rsp_free_ff, rsp_frame_ff, rsp_page_ff, rsp_id_ff};

endmodule

// ===== sv/pfa_ctrl.sv =====
// frame allocator controller: sequences page count, allocate, emit and remove scans
module pfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pfa_pkg::stat_type stat,
   output pfa_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_A_RD,
      S_A_CHK,
      S_E_RD,
      S_E_CHK,
      S_R_RD,
      S_R_CHK,
      S_R_FIN,
      S_RESP
   } state_type;

   state_type                  state_ff, state_in;
   logic [pfa_pkg::STAT_W-1:0] code_ff, code_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.rsp_status = code_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               case (stat.req_op)
                  pfa_pkg::OP_ALLOC: begin
                     if (stat.req_size_zero) begin
                        code_in  = pfa_pkg::ST_BAD_SIZE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  pfa_pkg::OP_REMOVE: begin
                     if (stat.active_zero) begin
                        code_in  = pfa_pkg::ST_NOT_FOUND;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_R_RD;
                     end
                  end
                  pfa_pkg::OP_CLEAR: begin
                     cmd.do_clear = 1'b1;
                     code_in      = pfa_pkg::ST_OK;
                     state_in     = S_RESP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (stat.rem_zero) begin
               cmd.start_alloc = 1'b1;
               state_in        = S_A_RD;
            end else if (stat.pages_eq_free) begin
               code_in  = pfa_pkg::ST_NO_FRAMES;
               state_in = S_RESP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_A_RD: begin
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (stat.frame_free) begin
               cmd.take_frame = 1'b1;
            end
            if ((stat.frame_free && stat.pg_last) || stat.left_one) begin
               cmd.restart_scan = 1'b1;
               state_in         = S_E_RD;
            end else begin
               cmd.dec_left = 1'b1;
               state_in     = S_A_RD;
            end
         end
         S_E_RD: begin
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            if (stat.frame_emit) begin
               // hold the scan until the result register can take the item
               if (stat.slot_free) begin
                  cmd.emit_map = 1'b1;
                  cmd.dec_left = 1'b1;
                  state_in     = (stat.pg_last || stat.left_one) ? S_IDLE : S_E_RD;
               end
            end else begin
               cmd.dec_left = 1'b1;
               state_in     = stat.left_one ? S_IDLE : S_E_RD;
            end
         end
         S_R_RD: begin
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            cmd.clear_owner = stat.frame_owned;
            cmd.dec_left    = 1'b1;
            state_in        = stat.left_one ? S_R_FIN : S_R_RD;
         end
         S_R_FIN: begin
            cmd.finish_remove = 1'b1;
            code_in  = stat.freed_zero ? pfa_pkg::ST_NOT_FOUND : pfa_pkg::ST_OK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.slot_free) begin
               cmd.emit_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= pfa_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ===== dv/testbench.sv =====
// self-checking stream testbench for the paged frame allocator: shadow frame table, random traffic
`timescale 1ns / 100ps

module testbench;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES = 600;
   localparam logic [pfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [pfa_pkg::OP_W-1:0]   op;
      logic [pfa_pkg::SIZE_W-1:0] size_kb;
      logic [pfa_pkg::PID_W-1:0]  pid;
      bit                         drain;
   } frame_req_type;

   typedef struct {
      logic [pfa_pkg::STAT_W-1:0]    status;
      logic [pfa_pkg::OUT_ID_W-1:0]  pid;
      logic [pfa_pkg::OUT_IDX_W-1:0] page;
      logic [pfa_pkg::OUT_IDX_W-1:0] frame;
      logic [pfa_pkg::OUT_CNT_W-1:0] free_cnt;
      bit                            last;
   } frame_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pfa_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // process_size_kb, process_number
   logic [pfa_pkg::OP_W-1:0]       req_tuser = '0;   // op
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // assigned_id, page_number, frame_number, free_count
   logic [pfa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [pfa_pkg::STAT_W-1:0]     rsp_tuser;        // status
   logic                           rsp_tlast;
   logic                           csr_we = 1'b0;
   logic [pfa_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [pfa_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the frame table and registers
   logic [pfa_pkg::PID_W-1:0]     owner [TABLE_DEPTH];
   logic [pfa_pkg::OUT_IDX_W-1:0] held_page [TABLE_DEPTH];
   int unsigned                   free_frames;
   logic [pfa_pkg::PID_W-1:0]     next_pid;
   logic [pfa_pkg::PSIZE_W-1:0]   shadow_page_kb;
   logic [pfa_pkg::FRAMES_W-1:0]  shadow_frames;

   frame_req_type queued_reqs[$];
   frame_rsp_type owed_replies[$];

   frame_req_type on_bus, staged_req;
   bit         staged = 1'b0;
   int         send_gap = 0;
   bit         send_idle = 1'b1;
   bit         recv_idle = 1'b1;
   int         recv_pause = 0;
   int         hold_asks = 0;
   int         hold_seen = 0;
   int         hold_left = 0;
   int         allocs_issued = 0;
   int         mismatches = 0;
   int         req_count = 0;
   int         reply_count = 0;
   int         reg_writes = 0;
   int         cycle_count = 0;

   paged_frame_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int draw_pause(input bit enabled);
      if (!enabled || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic void owe_reply(input logic [pfa_pkg::STAT_W-1:0] status,
                                     input logic [pfa_pkg::PID_W-1:0] pid,
                                     input int unsigned page, input int unsigned frame,
                                     input bit last);
      frame_rsp_type r;
      r.status   = status;
      r.pid      = pid;
      r.page     = pfa_pkg::OUT_IDX_W'(page);
      r.frame    = pfa_pkg::OUT_IDX_W'(frame);
      r.free_cnt = pfa_pkg::OUT_CNT_W'(free_frames);
      r.last     = last;
      owed_replies.insert(owed_replies.size(), r);
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         owner[i]     = '0;
         held_page[i] = '0;
      end
      free_frames = (shadow_frames > TABLE_DEPTH) ? TABLE_DEPTH : shadow_frames;
      next_pid    = pfa_pkg::PID_W'(1);
   endfunction

   // updates the shadow table for one accepted item and queues the replies it owes
   function automatic void serve_request(input frame_req_type r);
      int unsigned active, eff_page, pages, k, freed;
      logic [pfa_pkg::PID_W-1:0] id;
      active = (shadow_frames > TABLE_DEPTH) ? TABLE_DEPTH : shadow_frames;
      case (r.op)
         pfa_pkg::OP_ALLOC: begin
            eff_page = (shadow_page_kb == 0) ? 1 : shadow_page_kb;
            if (r.size_kb == 0) begin
               owe_reply(pfa_pkg::ST_BAD_SIZE, '0, 0, 0, 1'b1);
            end else begin
               pages = (r.size_kb + eff_page - 1) / eff_page;
               if (pages > free_frames) begin
                  owe_reply(pfa_pkg::ST_NO_FRAMES, '0, 0, 0, 1'b1);
               end else begin
                  id = next_pid;
                  k  = 0;
                  // highest free frames first
                  for (int i = int'(active) - 1; i >= 0 && k < pages; i--) begin
                     if (owner[i] == 0) begin
                        owner[i]     = id;
                        held_page[i] = pfa_pkg::OUT_IDX_W'(k);
                        k++;
                     end
                  end
                  free_frames -= pages;
                  next_pid = (id == '1) ? pfa_pkg::PID_W'(1) : id + 1'b1;
                  // mappings go out in page order, first matching frame from the top
                  k = 0;
                  for (int i = int'(active) - 1; i >= 0 && k < pages; i--) begin
                     if (owner[i] == id && held_page[i] == k) begin
                        owe_reply(pfa_pkg::ST_OK, id, k, i, k + 1 == pages);
                        k++;
                     end
                  end
               end
            end
         end
         pfa_pkg::OP_REMOVE: begin
            freed = 0;
            if (r.pid != 0) begin
               for (int i = 0; i < int'(active); i++) begin
                  if (owner[i] == r.pid) begin
                     owner[i]     = '0;
                     held_page[i] = '0;
                     freed++;
                  end
               end
            end
            free_frames += freed;
            owe_reply((freed == 0) ? pfa_pkg::ST_NOT_FOUND : pfa_pkg::ST_OK, r.pid, 0, 0, 1'b1);
         end
         pfa_pkg::OP_CLEAR: begin
            clear_table();
            owe_reply(pfa_pkg::ST_OK, '0, 0, 0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_req(input logic [pfa_pkg::OP_W-1:0] op,
                                     input logic [pfa_pkg::SIZE_W-1:0] size_kb,
                                     input logic [pfa_pkg::PID_W-1:0] pid, input bit drain);
      frame_req_type r;
      r.op      = op;
      r.size_kb = size_kb;
      r.pid     = pid;
      r.drain   = drain;
      queued_reqs.insert(queued_reqs.size(), r);
      if (op == pfa_pkg::OP_CLEAR) allocs_issued = 0;
      if (op == pfa_pkg::OP_ALLOC) allocs_issued++;
   endfunction

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            serve_request(on_bus);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (!staged && queued_reqs.size() != 0) begin
               staged_req = queued_reqs.pop_front();
               staged     = 1'b1;
               send_gap   = draw_pause(send_idle);
            end
            // a drain item is held back until every owed reply has come
            if (staged && send_gap == 0 && !(staged_req.drain && owed_replies.size() != 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {staged_req.pid, staged_req.size_kb};
               req_tuser  <= staged_req.op;
               on_bus = staged_req;
               staged = 1'b0;
            end else begin
               req_tvalid <= 1'b0;
               if (staged && send_gap != 0) send_gap--;
            end
         end
      end
   end

   always @(posedge clock) begin : reply_monitor
      frame_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            reply_count++;
            if (owed_replies.size() == 0) begin
               $error("unexpected reply: status %0d, assigned_id %0d", rsp_tuser,
                      rsp_tdata[15:0]);
               mismatches++;
            end else begin
               want = owed_replies.pop_front();
               check_field("status", want.status, rsp_tuser);
               check_field("assigned_id", want.pid, rsp_tdata[15:0]);
               check_field("page_number", want.page, rsp_tdata[21:16]);
               check_field("frame_number", want.frame, rsp_tdata[27:22]);
               check_field("free_count", want.free_cnt, rsp_tdata[34:28]);
               check_field("last", want.last, rsp_tlast);
            end
            recv_pause = draw_pause(recv_idle);
         end
         if (hold_seen != hold_asks) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_asks;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_pause != 0) begin
            recv_pause--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL paged_frame_allocator");
         $finish;
      end
   end

   task automatic settle();
      while (queued_reqs.size() != 0 || staged || req_tvalid || owed_replies.size() != 0)
         @(posedge clock);
      // the block may still be walking the table after its last item
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pfa_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [pfa_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      if (idx == pfa_pkg::CSR_PAGE_SIZE) begin
         shadow_page_kb = val[pfa_pkg::PSIZE_W-1:0];
      end else begin
         shadow_frames = val[pfa_pkg::FRAMES_W-1:0];
         clear_table();
         allocs_issued = 0;
      end
      reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // frames below zero leaves the frame count and the table as they are
   task automatic run_phase(input logic [pfa_pkg::CSR_DATA_W-1:0] pkb, input int frames,
                            input int count, input bit stress);
      int unsigned eff;
      int unsigned pick;
      logic [pfa_pkg::SIZE_W-1:0] size_kb;
      logic [pfa_pkg::PID_W-1:0] pid;
      logic [pfa_pkg::OP_W-1:0] op;
      settle();
      write_reg(pfa_pkg::CSR_PAGE_SIZE, pkb);
      if (frames >= 0) write_reg(pfa_pkg::CSR_FRAMES, pfa_pkg::CSR_DATA_W'(frames));
      eff = (pkb[pfa_pkg::PSIZE_W-1:0] == 0) ? 1 : pkb[pfa_pkg::PSIZE_W-1:0];
      send_idle = stress ? 1'b0 : ($urandom_range(0, 2) != 0);
      recv_idle = $urandom_range(0, 2) != 0;
      for (int n = 0; n < count; n++) begin
         pick    = $urandom_range(0, 99);
         size_kb = pfa_pkg::SIZE_W'($urandom);
         pid     = pfa_pkg::PID_W'($urandom);
         if (pick < 52) begin
            op = pfa_pkg::OP_ALLOC;
            case ($urandom_range(0, 11))
               0: size_kb = '0;
               1: ;   // full range, mostly too many pages
               default: size_kb = pfa_pkg::SIZE_W'($urandom_range(1, eff * $urandom_range(1, 6)));
            endcase
         end else if (pick < 90) begin
            op = pfa_pkg::OP_REMOVE;
            case ($urandom_range(0, 9))
               0: pid = '0;
               1: ;
               default: begin
                  if (allocs_issued != 0) pid = pfa_pkg::PID_W'($urandom_range(1, allocs_issued));
               end
            endcase
         end else if (pick < 95) begin
            op = pfa_pkg::OP_CLEAR;
         end else begin
            op = OP_UNUSED;
         end
         queue_req(op, size_kb, pid, $urandom_range(0, 29) == 0);
         if (stress && n == 2) hold_asks++;
      end
   endtask

   initial begin : stimulus
      shadow_page_kb = pfa_pkg::PAGE_SIZE_RST;
      shadow_frames  = pfa_pkg::FRAMES_RST;
      clear_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values: 4 KB pages, 64 frames
      queue_req(pfa_pkg::OP_ALLOC, 16'd0, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_ALLOC, 16'd1, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_ALLOC, 16'd4, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_ALLOC, 16'd5, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_ALLOC, 16'hFFFF, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_REMOVE, pfa_pkg::SIZE_W'($urandom), 16'd0, 1'b0);
      queue_req(pfa_pkg::OP_REMOVE, pfa_pkg::SIZE_W'($urandom), 16'd2, 1'b0);
      queue_req(pfa_pkg::OP_REMOVE, pfa_pkg::SIZE_W'($urandom), 16'd2, 1'b0);
      queue_req(pfa_pkg::OP_REMOVE, pfa_pkg::SIZE_W'($urandom), 16'hFFFF, 1'b0);
      queue_req(OP_UNUSED, pfa_pkg::SIZE_W'($urandom), pfa_pkg::PID_W'($urandom), 1'b0);
      // takes every remaining frame
      queue_req(pfa_pkg::OP_ALLOC, 16'd244, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_ALLOC, 16'd1, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_REMOVE, pfa_pkg::SIZE_W'($urandom), 16'd3, 1'b0);
      // refills the hole
      queue_req(pfa_pkg::OP_ALLOC, 16'd8, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_CLEAR, pfa_pkg::SIZE_W'($urandom), pfa_pkg::PID_W'($urandom), 1'b0);
      // all 64 pages at once
      queue_req(pfa_pkg::OP_ALLOC, 16'd256, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_ALLOC, 16'd1, pfa_pkg::PID_W'($urandom), 1'b0);
      queue_req(pfa_pkg::OP_REMOVE, pfa_pkg::SIZE_W'($urandom), 16'd1, 1'b1);

      run_phase(11'd0, 4, 25, 1'b0);
      run_phase(11'd1024, 1, 20, 1'b0);
      run_phase(11'd2047, 127, 35, 1'b0);
      run_phase(11'd1, 0, 10, 1'b0);
      run_phase(11'd3, 64, 40, 1'b1);
      run_phase(11'd16, -1, 20, 1'b0);
      repeat (3) begin
         run_phase(pfa_pkg::CSR_DATA_W'($urandom_range(1, 1024)), $urandom_range(1, 64), 30,
                   1'b0);
      end
      run_phase(pfa_pkg::CSR_DATA_W'(pfa_pkg::PAGE_SIZE_RST), int'(pfa_pkg::FRAMES_RST), 20,
                1'b0);
      settle();

      $display("covered %0d request items, %0d replies and %0d register writes", req_count,
               reply_count, reg_writes);
      $display("page sizes 0 to 2047 KB, frame counts 0 to 127, long output stall and drains");
      if (mismatches == 0 && owed_replies.size() == 0) begin
         $display("PASS paged_frame_allocator");
      end else begin
         $display("FAIL paged_frame_allocator");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/pfa_pkg.sv
sv/pfa_ram.sv
sv/pfa_dp.sv
sv/pfa_ctrl.sv
sv/paged_frame_allocator.sv
dv/testbench.sv
